// File: hdl/seven_segment_display_frame_encoder_unit_macros.svh
// Assertion macros shared by the display frame encoder RTL.
// Each macro takes the clock and the active-low reset of the module that uses it.
`ifndef SEVEN_SEGMENT_DISPLAY_FRAME_ENCODER_UNIT_MACROS_SVH
`define SEVEN_SEGMENT_DISPLAY_FRAME_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define SSDFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssdfe assertion failed: same-cycle implication");

// Next-cycle implication.
`define SSDFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssdfe assertion failed: next-cycle implication");

`endif

// File: hdl/ssdfe_pkg.sv
// Shared types, constants and tables of the seven-segment frame encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ssdfe_pkg;

    localparam int DIGITS_DEF = 4;

    localparam logic [7:0] BLANK_SEG   = 8'hFF;
    localparam logic [7:0] BLANK_SEL   = 8'h00;
    localparam logic [7:0] SEL_LEFTMOST = 8'h80;
    localparam logic [4:0] BASE_MIN    = 5'd2;
    localparam logic [4:0] BASE_MAX    = 5'd16;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_DIGIT  = 2'd1,
        CMD_NUMBER = 2'd2
    } cmd_e;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] number;
        logic [4:0]  radix;
        logic [1:0]  position;
        logic [3:0]  hex_digit;
        logic        decimal_point;
    } in_t;

    typedef struct packed {
        logic [7:0] segment_byte;
        logic [7:0] select_byte;
        logic       last;
    } out_t;

    // Item state carried down the divider pipeline.
    typedef struct packed {
        cmd_e        func;
        logic [15:0] cur;
        logic [4:0]  base;
        logic [15:0] recip;
        logic [1:0]  pos;
        logic [3:0]  dig;
        logic        dp;
    } item_t;

    // Active-low segment pattern a..g of a hex digit.
    function automatic logic [6:0] seg_pattern(input logic [3:0] d);
        logic [6:0] p;
        begin
            case (d)
                4'h0: p = 7'h01;
                4'h1: p = 7'h4F;
                4'h2: p = 7'h12;
                4'h3: p = 7'h06;
                4'h4: p = 7'h4C;
                4'h5: p = 7'h24;
                4'h6: p = 7'h20;
                4'h7: p = 7'h0F;
                4'h8: p = 7'h00;
                4'h9: p = 7'h04;
                4'hA: p = 7'h08;
                4'hB: p = 7'h60;
                4'hC: p = 7'h72;
                4'hD: p = 7'h42;
                4'hE: p = 7'h30;
                4'hF: p = 7'h38;
                default: p = 7'h7F;
            endcase
            return p;
        end
    endfunction

    function automatic logic [7:0] seg_byte(input logic [3:0] d, input logic point);
        begin
            return {seg_pattern(d), ~point};
        end
    endfunction

    // floor(65536 / base) for base 2..16; quotient estimate is low by at most one.
    function automatic logic [15:0] recip(input logic [4:0] b);
        logic [15:0] r;
        begin
            case (b)
                5'd2:  r = 16'd32768;
                5'd3:  r = 16'd21845;
                5'd4:  r = 16'd16384;
                5'd5:  r = 16'd13107;
                5'd6:  r = 16'd10922;
                5'd7:  r = 16'd9362;
                5'd8:  r = 16'd8192;
                5'd9:  r = 16'd7281;
                5'd10: r = 16'd6553;
                5'd11: r = 16'd5957;
                5'd12: r = 16'd5461;
                5'd13: r = 16'd5041;
                5'd14: r = 16'd4681;
                5'd15: r = 16'd4369;
                5'd16: r = 16'd4096;
                default: r = 16'd4096;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/ssdfe_div_step.sv
// One digit of the radix split: multiply by reciprocal, then correct and peel the digit.
// Two elastic register stages; depends on ssdfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssdfe_div_step #(
    parameter int DIGITS = ssdfe_pkg::DIGITS_DEF,
    parameter int IDX    = 0
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output      logic                    in_ready,
    input  wire ssdfe_pkg::item_t        in_item,
    input  wire logic [4*DIGITS-1:0]     in_digits,
    output      logic                    out_valid,
    input  wire logic                    out_ready,
    output      ssdfe_pkg::item_t        out_item,
    output      logic [4*DIGITS-1:0]     out_digits
);

    localparam int DW = 4 * DIGITS;

    logic                a_valid_reg;
    ssdfe_pkg::item_t    a_item_reg;
    logic [DW-1:0]       a_digits_reg;
    logic [31:0]         a_prod_reg;
    logic                a_ready;

    logic                b_valid_reg;
    ssdfe_pkg::item_t    b_item_reg;
    logic [DW-1:0]       b_digits_reg;
    logic                b_ready;

    logic [15:0]         q0;
    logic [20:0]         qb;
    logic [15:0]         rem0;
    logic [15:0]         q_next;
    logic [15:0]         rem;
    ssdfe_pkg::item_t    b_item_next;
    logic [DW-1:0]       b_digits_next;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_item_reg   <= in_item;
            a_digits_reg <= in_digits;
            a_prod_reg   <= 32'(in_item.cur) * 32'(in_item.recip);
        end
    end

    // Quotient estimate is never high and at most one low: one correction step.
    always_comb
    begin
        q0   = a_prod_reg[31:16];
        qb   = 21'(q0) * 21'(a_item_reg.base);
        rem0 = a_item_reg.cur - qb[15:0];
        if (rem0 >= 16'(a_item_reg.base))
        begin
            q_next = q0 + 16'd1;
            rem    = rem0 - 16'(a_item_reg.base);
        end
        else
        begin
            q_next = q0;
            rem    = rem0;
        end
        b_item_next             = a_item_reg;
        b_item_next.cur         = q_next;
        b_digits_next           = a_digits_reg;
        b_digits_next[IDX*4 +: 4] = rem[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_item_reg   <= b_item_next;
            b_digits_reg <= b_digits_next;
        end
    end

    assign out_valid  = b_valid_reg;
    assign out_item   = b_item_reg;
    assign out_digits = b_digits_reg;

endmodule

`default_nettype wire

// File: hdl/ssdfe_frame_out.sv
// Frame serializer: turns one finished item into its frames, one per cycle, registered.
// Depends on ssdfe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "seven_segment_display_frame_encoder_unit_macros.svh"

module ssdfe_frame_out #(
    parameter int DIGITS = ssdfe_pkg::DIGITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output      logic                    in_ready,
    input  wire ssdfe_pkg::item_t        in_item,
    input  wire logic [4*DIGITS-1:0]     in_digits,
    output      logic                    strobe,
    output      ssdfe_pkg::out_t         result
);

    localparam int DW    = 4 * DIGITS;
    localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic                hold_valid_reg;
    ssdfe_pkg::item_t    hold_item_reg;
    logic [DW-1:0]       hold_digits_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                strobe_reg;
    ssdfe_pkg::out_t     res_reg;
    ssdfe_pkg::out_t     res_next;
    logic                fin;

    always_comb
    begin
        fin = (hold_item_reg.func != ssdfe_pkg::CMD_NUMBER) ||
              (cnt_reg == CNT_W'(DIGITS - 1));
        case (hold_item_reg.func)
            ssdfe_pkg::CMD_CLEAR:
            begin
                res_next.segment_byte = ssdfe_pkg::BLANK_SEG;
                res_next.select_byte  = ssdfe_pkg::BLANK_SEL;
                res_next.last         = 1'b1;
            end
            ssdfe_pkg::CMD_DIGIT:
            begin
                res_next.segment_byte = ssdfe_pkg::seg_byte(hold_item_reg.dig,
                                                            hold_item_reg.dp);
                res_next.select_byte  = ssdfe_pkg::SEL_LEFTMOST >> hold_item_reg.pos;
                res_next.last         = 1'b1;
            end
            ssdfe_pkg::CMD_NUMBER:
            begin
                res_next.segment_byte = ssdfe_pkg::seg_byte(hold_digits_reg[cnt_reg*4 +: 4],
                                                            1'b0);
                res_next.select_byte  = ssdfe_pkg::SEL_LEFTMOST >> cnt_reg;
                res_next.last         = (cnt_reg == CNT_W'(DIGITS - 1));
            end
            default:
            begin
                res_next.segment_byte = ssdfe_pkg::BLANK_SEG;
                res_next.select_byte  = ssdfe_pkg::BLANK_SEL;
                res_next.last         = 1'b1;
            end
        endcase
    end

    // Take the next item as the current one emits its final frame.
    assign in_ready = !hold_valid_reg || fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= hold_valid_reg;
            if (in_ready)
            begin
                hold_valid_reg <= in_valid;
                cnt_reg        <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_item_reg   <= in_item;
            hold_digits_reg <= in_digits;
        end
        if (hold_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

    // A number command emits its frames in consecutive cycles.
    `SSDFE_ASSERT_NEXT(a_frames_back_to_back, clk, rst_n, strobe_reg && !res_reg.last, strobe_reg)
    `SSDFE_ASSERT_IMPL(a_select_one_hot, clk, rst_n, strobe_reg, $onehot0(res_reg.select_byte) && (res_reg.select_byte[3:0] == 4'b0000))
    // Only number frames are not last, and they never light the point.
    `SSDFE_ASSERT_IMPL(a_point_off_mid_number, clk, rst_n, strobe_reg && !res_reg.last, res_reg.segment_byte[0])

endmodule

`default_nettype wire

// File: hdl/seven_segment_display_frame_encoder_unit.sv
// Top level of the seven-segment frame encoder: entry register, divider chain, serializer.
// Depends on ssdfe_pkg, ssdfe_div_step and ssdfe_frame_out.
`timescale 1ns / 1ps
`default_nettype none

// A command transfers at a rising edge with start high and busy low. Clear and
// single-digit commands give one frame, a number command gives DIGITS frames in
// consecutive cycles, and code three gives none. Frames appear on result with
// strobe high for one cycle each; the receiver must take them as they come.
// The first frame of a command passes the entry register, which loads at its
// transfer edge, then two stages per digit of the reciprocal divider chain,
// then the serializer and its output register. Clear and digit commands
// sustain one per cycle while nothing backs up; number commands are limited
// by the serializer emitting one frame per cycle, and busy rises while it
// backs up.
module seven_segment_display_frame_encoder_unit #(
    parameter int DIGITS = ssdfe_pkg::DIGITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output      logic             busy,
    input  wire ssdfe_pkg::in_t   cmd,
    output      logic             strobe,
    output      ssdfe_pkg::out_t  result
);

    localparam int DW = 4 * DIGITS;

    logic                s0_valid_reg;
    ssdfe_pkg::item_t    s0_item_reg;
    ssdfe_pkg::item_t    s0_item_next;
    logic                s0_ready;
    logic                cmd_known;

    logic                link_valid [DIGITS+1];
    logic                link_ready [DIGITS+1];
    ssdfe_pkg::item_t    link_item  [DIGITS+1];
    logic [DW-1:0]       link_digits [DIGITS+1];

    always_comb
    begin
        cmd_known = (cmd.func == ssdfe_pkg::CMD_CLEAR) ||
                    (cmd.func == ssdfe_pkg::CMD_DIGIT) ||
                    (cmd.func == ssdfe_pkg::CMD_NUMBER);
        s0_item_next.func = ssdfe_pkg::cmd_e'(cmd.func);
        s0_item_next.cur  = cmd.number;
        if (cmd.radix inside {[ssdfe_pkg::BASE_MIN:ssdfe_pkg::BASE_MAX]})
        begin
            s0_item_next.base = cmd.radix;
        end
        else if (cmd.radix < ssdfe_pkg::BASE_MIN)
        begin
            s0_item_next.base = ssdfe_pkg::BASE_MIN;
        end
        else
        begin
            s0_item_next.base = ssdfe_pkg::BASE_MAX;
        end
        s0_item_next.recip = ssdfe_pkg::recip(s0_item_next.base);
        s0_item_next.pos   = cmd.position;
        s0_item_next.dig   = cmd.hex_digit;
        s0_item_next.dp    = cmd.decimal_point;
    end

    assign s0_ready = !s0_valid_reg || link_ready[0];
    assign busy     = !s0_ready;

    // Drop the unused command code at entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= start && cmd_known;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && start)
        begin
            s0_item_reg <= s0_item_next;
        end
    end

    assign link_valid[0]  = s0_valid_reg;
    assign link_item[0]   = s0_item_reg;
    assign link_digits[0] = '0;

    for (genvar i = 0; i < DIGITS; i++)
    begin : g_step
        ssdfe_div_step #(
            .DIGITS (DIGITS),
            .IDX    (i)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (link_valid[i]),
            .in_ready   (link_ready[i]),
            .in_item    (link_item[i]),
            .in_digits  (link_digits[i]),
            .out_valid  (link_valid[i+1]),
            .out_ready  (link_ready[i+1]),
            .out_item   (link_item[i+1]),
            .out_digits (link_digits[i+1])
        );
    end

    ssdfe_frame_out #(
        .DIGITS (DIGITS)
    ) u_frame_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[DIGITS]),
        .in_ready  (link_ready[DIGITS]),
        .in_item   (link_item[DIGITS]),
        .in_digits (link_digits[DIGITS]),
        .strobe    (strobe),
        .result    (result)
    );

endmodule

`default_nettype wire
